FILE: rtl/pid_term_rms_monitor_macros.svh
// Assertion macros for the PID term RMS monitor.
// Included by the top level; needs no other file.
`ifndef PID_TERM_RMS_MONITOR_MACROS_SVH
`define PID_TERM_RMS_MONITOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PTRM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PTRM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ptrm_pkg.sv
// Shared constants for the PID term RMS monitor: field and lane counts,
// filter coefficients and square root selection codes. No dependencies.
package ptrm_pkg;

  localparam int NUM_FIELDS = 9;
  localparam int NUM_LANES  = 5;
  localparam int NUM_ROOTS  = 7;

  // Input field positions in tdata
  localparam int F_ROLL_P   = 0;
  localparam int F_ROLL_FF  = 1;
  localparam int F_ROLL_D   = 2;
  localparam int F_PITCH_P  = 3;
  localparam int F_PITCH_FF = 4;
  localparam int F_PITCH_D  = 5;
  localparam int F_YAW_P    = 6;
  localparam int F_YAW_D    = 7;
  localparam int F_YAW_FF   = 8;

  // Mean square lanes
  localparam int L_ROLL_P  = 0;
  localparam int L_ROLL_D  = 1;
  localparam int L_PITCH_P = 2;
  localparam int L_PITCH_D = 3;
  localparam int L_YAW     = 4;

  // Low-pass weights in Q0.16, pole 0.99
  localparam logic [15:0] FILT_KEEP  = 16'd64881;
  localparam logic [15:0] FILT_TAKE  = 16'd655;
  localparam int          FILT_STEPS = 16;

  // Square root selection, in result order
  localparam logic [2:0] ROOT_ROLL    = 3'd0;
  localparam logic [2:0] ROOT_ROLL_P  = 3'd1;
  localparam logic [2:0] ROOT_ROLL_D  = 3'd2;
  localparam logic [2:0] ROOT_PITCH   = 3'd3;
  localparam logic [2:0] ROOT_PITCH_P = 3'd4;
  localparam logic [2:0] ROOT_PITCH_D = 3'd5;
  localparam logic [2:0] ROOT_YAW     = 3'd6;

endpackage

FILE: rtl/pid_term_rms_monitor.sv
// PID term RMS monitor: serial squares, 0.99 low-pass mean squares and
// a shared bit-serial square root. Depends on ptrm_pkg and the macros header.
//
// A request is accepted in the idle state and passes through five bit-serial
// squarers, the bit-serial low-pass update, then seven roots through one
// restoring square root unit at one result bit per cycle, each after a load
// step, and a done state that hands the result over once the output register
// is free. A finished result waits in the output register while the next
// request is taken; input is not accepted while a request is being worked on.
`include "pid_term_rms_monitor_macros.svh"

module pid_term_rms_monitor #(
  parameter  int SAMPLE_WIDTH = 16,
  localparam int IN_W  = ((ptrm_pkg::NUM_FIELDS * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((ptrm_pkg::NUM_ROOTS * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // roll_p, roll_ff, roll_d, pitch_p, pitch_ff, pitch_d, yaw_p, yaw_d, yaw_ff
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // roll_rms, roll_p_rms, roll_d_rms, pitch_rms, pitch_p_rms, pitch_d_rms, yaw_rms
  output logic [OUT_W-1:0] m_tdata
);
  import ptrm_pkg::*;

  localparam int W     = SAMPLE_WIDTH;
  localparam int SUM_W = W + 2;
  localparam int MS_W  = 2 * W - 1;
  localparam int ACC_W = 2 * W;
  localparam int RW    = W + 2;
  localparam int RES_W = NUM_ROOTS * W;
  localparam int CNT_W = (W > FILT_STEPS) ? $clog2(W) : $clog2(FILT_STEPS);

  localparam logic signed [SUM_W-1:0] SAT_HI = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {3'b111, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_FILTER,
    ST_LOAD,
    ST_ROOT,
    ST_DONE
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [2:0]          root_idx;

  logic [W-1:0]        mag    [NUM_LANES];
  logic [W-1:0]        mshift [NUM_LANES];
  logic [MS_W-1:0]     sq     [NUM_LANES];
  logic [ACC_W-1:0]    acc    [NUM_LANES];
  logic [MS_W-1:0]     ms     [NUM_LANES];

  logic [ACC_W-1:0]    xs;
  logic [RW-1:0]       rem;
  logic [W-1:0]        root;
  logic [RES_W-1:0]    res;

  // Input side: channel sums, clamp, magnitude
  logic signed [SUM_W-1:0] fld   [NUM_FIELDS];
  logic signed [SUM_W-1:0] chan  [NUM_LANES];
  logic signed [SUM_W-1:0] clamp [NUM_LANES];
  logic signed [SUM_W-1:0] negv  [NUM_LANES];
  logic [W-1:0]            mag_in [NUM_LANES];

  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      fld[k] = SUM_W'(signed'(s_tdata[k*W +: W]));
    end
    chan[L_ROLL_P]  = fld[F_ROLL_P] + fld[F_ROLL_FF];
    chan[L_ROLL_D]  = fld[F_ROLL_D];
    chan[L_PITCH_P] = fld[F_PITCH_P] + fld[F_PITCH_FF];
    chan[L_PITCH_D] = fld[F_PITCH_D];
    chan[L_YAW]     = fld[F_YAW_P] + fld[F_YAW_D] + fld[F_YAW_FF];
    for (int l = 0; l < NUM_LANES; l++) begin
      if (chan[l] > SAT_HI) begin
        clamp[l] = SAT_HI;
      end else if (chan[l] < SAT_LO) begin
        clamp[l] = SAT_LO;
      end else begin
        clamp[l] = chan[l];
      end
      negv[l]   = -clamp[l];
      mag_in[l] = clamp[l][SUM_W-1] ? negv[l][W-1:0] : clamp[l][W-1:0];
    end
  end

  // Serial square and low-pass steps, one per lane
  logic [3:0]       fbit;
  logic [MS_W-1:0]  sq_next  [NUM_LANES];
  logic [ACC_W:0]   acc_sum  [NUM_LANES];

  assign fbit = cnt[3:0];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      sq_next[l] = {sq[l][MS_W-2:0], 1'b0}
                 + (mshift[l][W-1] ? MS_W'(mag[l]) : '0);
      acc_sum[l] = (ACC_W+1)'(acc[l])
                 + (FILT_KEEP[fbit] ? (ACC_W+1)'(ms[l]) : '0)
                 + (FILT_TAKE[fbit] ? (ACC_W+1)'(sq[l]) : '0);
    end
  end

  // Square root operand select and one restoring step
  logic [ACC_W-1:0] root_op;
  logic [RW-1:0]    rem_shift;
  logic [RW-1:0]    trial;
  logic             take;
  logic [RW-1:0]    rem_next;
  logic [W-1:0]     root_next;

  always_comb begin
    unique case (root_idx)
      ROOT_ROLL:    root_op = ACC_W'(ms[L_ROLL_P]) + ACC_W'(ms[L_ROLL_D]);
      ROOT_ROLL_P:  root_op = ACC_W'(ms[L_ROLL_P]);
      ROOT_ROLL_D:  root_op = ACC_W'(ms[L_ROLL_D]);
      ROOT_PITCH:   root_op = ACC_W'(ms[L_PITCH_P]) + ACC_W'(ms[L_PITCH_D]);
      ROOT_PITCH_P: root_op = ACC_W'(ms[L_PITCH_P]);
      ROOT_PITCH_D: root_op = ACC_W'(ms[L_PITCH_D]);
      ROOT_YAW:     root_op = ACC_W'(ms[L_YAW]);
      default:      root_op = '0;
    endcase
    rem_shift = {rem[W-1:0], xs[ACC_W-1 -: 2]};
    trial     = {root, 2'b01};
    take      = rem_shift >= trial;
    rem_next  = take ? rem_shift - trial : rem_shift;
    root_next = {root[W-2:0], take};
  end

  assign s_tready = (state == ST_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      root_idx <= ROOT_ROLL;
      m_tvalid <= 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
        ms[l] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int l = 0; l < NUM_LANES; l++) begin
              mag[l]    <= mag_in[l];
              mshift[l] <= mag_in[l];
              sq[l]     <= '0;
            end
            cnt   <= '0;
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          for (int l = 0; l < NUM_LANES; l++) begin
            sq[l]     <= sq_next[l];
            mshift[l] <= {mshift[l][W-2:0], 1'b0};
            acc[l]    <= '0;
          end
          if (cnt == CNT_W'(W - 1)) begin
            cnt   <= '0;
            state <= ST_FILTER;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FILTER: begin
          for (int l = 0; l < NUM_LANES; l++) begin
            acc[l] <= acc_sum[l][ACC_W:1];
          end
          if (fbit == 4'(FILT_STEPS - 1)) begin
            // commit the updated mean squares
            for (int l = 0; l < NUM_LANES; l++) begin
              ms[l] <= acc_sum[l][MS_W:1];
            end
            cnt      <= '0;
            root_idx <= ROOT_ROLL;
            state    <= ST_LOAD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_LOAD: begin
          xs    <= root_op;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          xs   <= {xs[ACC_W-3:0], 2'b00};
          rem  <= rem_next;
          root <= root_next;
          if (cnt == CNT_W'(W - 1)) begin
            res <= {root_next, res[RES_W-1:W]};
            if (root_idx == ROOT_YAW) begin
              state <= ST_DONE;
            end else begin
              root_idx <= root_idx + 1'b1;
              state    <= ST_LOAD;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_W'(res);
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PTRM_ASSERT_NXT(a_accept_starts, clk, rst, s_tvalid && s_tready,
    state == ST_SQUARE && cnt == '0, "accepted request did not start squaring")
  `PTRM_ASSERT_NXT(a_last_root_done, clk, rst,
    state == ST_ROOT && cnt == CNT_W'(W - 1) && root_idx == ROOT_YAW,
    state == ST_DONE, "last root did not finish the request")
  `PTRM_ASSERT_IMP(a_rem_bound, clk, rst, state == ST_ROOT,
    rem <= (RW'(root) << 1), "square root remainder out of bound")

endmodule

FILE: dv/pid_term_rms_monitor_checker.sv
`timescale 1ns / 1ps
// Scoreboard for pid_term_rms_monitor: keeps its own mean square filters,
// predicts the root report for every accepted request and checks the output.
// Depends on ptrm_pkg.
module pid_term_rms_monitor_checker #(
  parameter int W     = 16,
  parameter int IN_W  = 144,
  parameter int OUT_W = 112
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               mismatches,
  output int               pending
);
  import ptrm_pkg::*;

  // Unsigned Q31.0 mean squares, one per lane
  logic [2*W-2:0] mean_sq [NUM_LANES];
  logic [OUT_W-1:0] rms_expected [$];

  function automatic longint signed term(input logic [IN_W-1:0] s, input int idx);
    return longint'($signed(s[idx*W +: W]));
  endfunction

  function automatic longint unsigned clamped_square(input longint signed total);
    longint signed hi;
    longint signed lo;
    hi = (longint'(1) <<< (W-1)) - 1;
    lo = -hi - 1;
    if (total > hi) total = hi;
    if (total < lo) total = lo;
    if (total < 0) total = -total;
    return longint'(total * total);
  endfunction

  function automatic logic [2*W-2:0] low_pass(input logic [2*W-2:0] old,
                                              input longint unsigned sq);
    longint unsigned acc;
    acc = 64'(FILT_KEEP) * 64'(old) + 64'(FILT_TAKE) * sq;
    acc = acc >> 16;
    return acc[2*W-2:0];
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x = x - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic logic [W-1:0] root_of(input logic [2*W-2:0] a, input logic [2*W-2:0] b);
    longint unsigned r;
    r = floor_root(64'(a) + 64'(b));
    return r[W-1:0];
  endfunction

  // Advance all five filters by one sample and return the root report.
  function automatic logic [OUT_W-1:0] predict_rms(input logic [IN_W-1:0] s);
    logic [OUT_W-1:0] rpt;
    mean_sq[L_ROLL_P] = low_pass(mean_sq[L_ROLL_P],
      clamped_square(term(s, F_ROLL_P) + term(s, F_ROLL_FF)));
    mean_sq[L_ROLL_D] = low_pass(mean_sq[L_ROLL_D], clamped_square(term(s, F_ROLL_D)));
    mean_sq[L_PITCH_P] = low_pass(mean_sq[L_PITCH_P],
      clamped_square(term(s, F_PITCH_P) + term(s, F_PITCH_FF)));
    mean_sq[L_PITCH_D] = low_pass(mean_sq[L_PITCH_D], clamped_square(term(s, F_PITCH_D)));
    mean_sq[L_YAW] = low_pass(mean_sq[L_YAW],
      clamped_square(term(s, F_YAW_P) + term(s, F_YAW_D) + term(s, F_YAW_FF)));
    rpt = '0;
    rpt[int'(ROOT_ROLL)*W +: W]    = root_of(mean_sq[L_ROLL_P], mean_sq[L_ROLL_D]);
    rpt[int'(ROOT_ROLL_P)*W +: W]  = root_of(mean_sq[L_ROLL_P], '0);
    rpt[int'(ROOT_ROLL_D)*W +: W]  = root_of(mean_sq[L_ROLL_D], '0);
    rpt[int'(ROOT_PITCH)*W +: W]   = root_of(mean_sq[L_PITCH_P], mean_sq[L_PITCH_D]);
    rpt[int'(ROOT_PITCH_P)*W +: W] = root_of(mean_sq[L_PITCH_P], '0);
    rpt[int'(ROOT_PITCH_D)*W +: W] = root_of(mean_sq[L_PITCH_D], '0);
    rpt[int'(ROOT_YAW)*W +: W]     = root_of(mean_sq[L_YAW], '0);
    return rpt;
  endfunction

  function automatic string root_label(input int r);
    case (r)
      int'(ROOT_ROLL):    return "roll_rms";
      int'(ROOT_ROLL_P):  return "roll_p_rms";
      int'(ROOT_ROLL_D):  return "roll_d_rms";
      int'(ROOT_PITCH):   return "pitch_rms";
      int'(ROOT_PITCH_P): return "pitch_p_rms";
      int'(ROOT_PITCH_D): return "pitch_d_rms";
      int'(ROOT_YAW):     return "yaw_rms";
      default:            return "unknown";
    endcase
  endfunction

  always @(posedge clk) begin : watch_channels
    logic [OUT_W-1:0] want;
    logic [W-1:0] got_f;
    logic [W-1:0] want_f;
    if (rst) begin
      for (int l = 0; l < NUM_LANES; l++) mean_sq[l] = '0;
      rms_expected.delete();
      mismatches = 0;
    end else begin
      // a finished report leaves before the next request's report exists
      if (m_tvalid && m_tready) begin
        if (rms_expected.size() == 0) begin
          $error("report with no request pending: %h", m_tdata);
          mismatches++;
        end else begin
          want = rms_expected.pop_front();
          for (int r = 0; r < NUM_ROOTS; r++) begin
            got_f  = m_tdata[r*W +: W];
            want_f = want[r*W +: W];
            if (got_f !== want_f) begin
              $error("%s: expected %0d, got %0d", root_label(r), want_f, got_f);
              mismatches++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) rms_expected.push_back(predict_rms(s_tdata));
    end
    pending = rms_expected.size();
  end

endmodule

FILE: dv/pid_term_rms_monitor_test.sv
`timescale 1ns / 1ps
// Top of the pid_term_rms_monitor testbench: clock, reset, controller samples
// with random gaps and back-pressure, and the verdict. Needs ptrm_pkg and the checker.
module pid_term_rms_monitor_test;
  import ptrm_pkg::*;

  localparam int W              = 16;
  localparam int IN_W           = ((NUM_FIELDS * W + 7) / 8) * 8;
  localparam int OUT_W          = ((NUM_ROOTS * W + 7) / 8) * 8;
  localparam int RANDOM_SAMPLES = 1350;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int SIDE_SEND      = 0;
  localparam int SIDE_RECV      = 1;

  localparam logic [W-1:0] POS_RAIL = 16'h7FFF;
  localparam logic [W-1:0] NEG_RAIL = 16'h8000;

  typedef enum int {MODE_FULL, MODE_RAIL, MODE_EDGE, MODE_SMALL, MODE_QUIET} term_mode_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int mismatches;
  int pending;
  int cycles = 0;
  int quiet_left [2] = '{0, 0};

  pid_term_rms_monitor #(.SAMPLE_WIDTH(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pid_term_rms_monitor_checker #(.W(W), .IN_W(IN_W), .OUT_W(OUT_W)) rms_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Draw a random wait, with occasional stretches of no waiting at all.
  function automatic int draw_wait(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [IN_W-1:0] pack_terms(
    input logic [W-1:0] rp, rf, rd, pp, pf, pd, yp, yd, yf);
    logic [IN_W-1:0] s;
    s = '0;
    s[F_ROLL_P*W +: W]   = rp;
    s[F_ROLL_FF*W +: W]  = rf;
    s[F_ROLL_D*W +: W]   = rd;
    s[F_PITCH_P*W +: W]  = pp;
    s[F_PITCH_FF*W +: W] = pf;
    s[F_PITCH_D*W +: W]  = pd;
    s[F_YAW_P*W +: W]    = yp;
    s[F_YAW_D*W +: W]    = yd;
    s[F_YAW_FF*W +: W]   = yf;
    return s;
  endfunction

  function automatic logic [W-1:0] draw_term(input term_mode_t mode);
    case (mode)
      MODE_FULL:  return W'($urandom);
      MODE_RAIL:  return $urandom_range(0, 1) ? POS_RAIL : NEG_RAIL;
      MODE_EDGE: begin
        case ($urandom_range(0, 5))
          0:       return POS_RAIL;
          1:       return NEG_RAIL;
          2:       return 16'hFFFF;
          3:       return 16'h0000;
          4:       return 16'h0001;
          default: return W'($urandom);
        endcase
      end
      MODE_SMALL: return W'($urandom_range(0, 511) - 256);
      default:    return '0;
    endcase
  endfunction

  task automatic push_sample(input logic [IN_W-1:0] sample);
    int gap;
    gap = draw_wait(SIDE_SEND);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin : back_pressure
    int stall;
    wait (!rst);
    forever begin
      stall = draw_wait(SIDE_RECV);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int burst;
    term_mode_t mode;
    logic [IN_W-1:0] s;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // rails, exact clamp boundaries and bit patterns
    push_sample(pack_terms('0, '0, '0, '0, '0, '0, '0, '0, '0));
    push_sample(pack_terms(POS_RAIL, POS_RAIL, POS_RAIL, POS_RAIL, POS_RAIL,
                           POS_RAIL, POS_RAIL, POS_RAIL, POS_RAIL));
    push_sample(pack_terms(NEG_RAIL, NEG_RAIL, NEG_RAIL, NEG_RAIL, NEG_RAIL,
                           NEG_RAIL, NEG_RAIL, NEG_RAIL, NEG_RAIL));
    push_sample(pack_terms(POS_RAIL, '0, POS_RAIL, NEG_RAIL, '0, NEG_RAIL,
                           POS_RAIL, '0, '0));
    push_sample(pack_terms(POS_RAIL, 16'h0001, 16'h0001, NEG_RAIL, 16'hFFFF, 16'hFFFF,
                           POS_RAIL, POS_RAIL, NEG_RAIL));
    push_sample(pack_terms(NEG_RAIL, POS_RAIL, NEG_RAIL, POS_RAIL, NEG_RAIL, POS_RAIL,
                           NEG_RAIL, NEG_RAIL, NEG_RAIL));
    push_sample(pack_terms(POS_RAIL, POS_RAIL, '0, NEG_RAIL, NEG_RAIL, '0,
                           POS_RAIL, POS_RAIL, POS_RAIL));
    push_sample(pack_terms('0, '0, '0, '0, '0, '0, NEG_RAIL, POS_RAIL, 16'h0001));
    push_sample(pack_terms(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
                           16'h5555, 16'h5555, 16'h5555, 16'h5555));
    push_sample(pack_terms(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                           16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA));
    push_sample(pack_terms(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                           16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    push_sample(pack_terms(16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010,
                           16'h0020, 16'h0040, 16'h0080, 16'h0100));
    push_sample(pack_terms(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (6) push_sample(pack_terms(POS_RAIL, POS_RAIL, NEG_RAIL, NEG_RAIL, NEG_RAIL,
                                      POS_RAIL, POS_RAIL, POS_RAIL, POS_RAIL));

    // bursts of one flavor each, so the filters climb to the rails and decay again
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      mode  = term_mode_t'($urandom_range(0, 4));
      burst = (mode == MODE_RAIL) ? $urandom_range(50, 400) : $urandom_range(10, 150);
      if (burst > RANDOM_SAMPLES - sent) burst = RANDOM_SAMPLES - sent;
      repeat (burst) begin
        for (int f = 0; f < NUM_FIELDS; f++) s[f*W +: W] = draw_term(mode);
        push_sample(s);
        sent++;
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
